>>> design/bsu_pkg.sv
// Shared types and constants of the branch and system-register unit.
// Used by every module of the block; depends on nothing.
`default_nettype none

package bsu_pkg;

    typedef enum logic [4:0] {
        OP_B     = 5'd0,
        OP_BL    = 5'd1,
        OP_BCOND = 5'd2,
        OP_CBZ   = 5'd3,
        OP_CBNZ  = 5'd4,
        OP_TBZ   = 5'd5,
        OP_TBNZ  = 5'd6,
        OP_BR    = 5'd7,
        OP_BLR   = 5'd8,
        OP_RET   = 5'd9,
        OP_SVC   = 5'd10,
        OP_BRK   = 5'd11,
        OP_HLT   = 5'd12,
        OP_CLREX = 5'd13,
        OP_HINT  = 5'd14,
        OP_MRS   = 5'd15,
        OP_MSR   = 5'd16
    } t_op;

    typedef enum logic [1:0] {
        ST_CONTINUE = 2'd0,
        ST_HALTED   = 2'd1,
        ST_SYSCALL  = 2'd2
    } t_status;

    localparam logic [4:0]  LINK_REG      = 5'd30;
    localparam logic [4:0]  ZERO_REG      = 5'd31;
    localparam logic [15:0] BRK_HALT_CODE = 16'd133;

    localparam logic [15:0] SR_TPIDR   = {2'd3, 3'd3, 4'd13, 4'd0, 3'd2};
    localparam logic [15:0] SR_TPIDRRO = {2'd3, 3'd3, 4'd13, 4'd0, 3'd3};
    localparam logic [15:0] SR_CTR     = {2'd3, 3'd3, 4'd0, 4'd0, 3'd1};
    localparam logic [15:0] SR_DCZID   = {2'd3, 3'd3, 4'd0, 4'd0, 3'd7};
    localparam logic [15:0] SR_NZCV    = {2'd3, 3'd3, 4'd4, 4'd2, 3'd0};
    localparam logic [15:0] SR_FPCR    = {2'd3, 3'd3, 4'd4, 4'd4, 3'd0};
    localparam logic [15:0] SR_FPSR    = {2'd3, 3'd3, 4'd4, 4'd4, 3'd1};
    localparam logic [15:0] SR_MIDR    = {2'd3, 3'd3, 4'd0, 4'd0, 3'd0};
    localparam logic [15:0] SR_ID_5    = {2'd3, 3'd3, 4'd0, 4'd0, 3'd5};
    localparam logic [15:0] SR_ID_6    = {2'd3, 3'd3, 4'd0, 4'd0, 3'd6};
    localparam logic [15:0] SR_ID_20   = {2'd3, 3'd3, 4'd0, 4'd2, 3'd0};

    localparam logic [31:0] VAL_CTR   = 32'h8444_C004;
    localparam logic [31:0] VAL_DCZID = 32'h0000_0010;
    localparam logic [31:0] VAL_MIDR  = 32'h410F_D080;
    localparam logic [31:0] VAL_ID_5  = 32'h1011_0222;
    localparam logic [31:0] VAL_ID_6  = 32'h1212_2211;
    localparam logic [31:0] VAL_ID_20 = 32'h0000_0022;

    typedef struct packed {
        logic [4:0]  op;
        logic [63:0] pc;
        logic [27:0] offset;
        logic [3:0]  cond;
        logic        wide;
        logic [5:0]  bit_pos;
        logic [63:0] reg_value;
        logic [4:0]  reg_index;
        logic [15:0] sysreg;
        logic [15:0] imm16;
        logic [3:0]  flags_in;
    } t_in_item;

    typedef struct packed {
        logic [63:0] next_pc;
        t_status     status;
        logic [15:0] halt_code;
        logic        reg_write;
        logic [4:0]  write_index;
        logic [63:0] write_data;
        logic        flags_write;
        logic [3:0]  flags_out;
        logic        clear_exclusive;
    } t_out_item;

    typedef struct packed {
        logic        en;
        logic [15:0] sel;
        logic [63:0] data;
    } t_sr_wr;

endpackage

`default_nettype wire

>>> design/bsu_sysregs.sv
// System register file: TPIDR, TPIDRRO, FPCR and FPSR plus the read decoder.
// Depends on bsu_pkg for the register encodings and the write request type.
`default_nettype none

module bsu_sysregs
    import bsu_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic [15:0] i_rd_sel,
    input  wire logic [3:0]  i_flags,
    input  wire t_sr_wr      i_wr,
    output logic [63:0]      o_rd_data
);

    logic [63:0] r_tpidr;
    logic [63:0] r_tpidrro;
    logic [31:0] r_fpcr;
    logic [31:0] r_fpsr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tpidr   <= '0;
            r_tpidrro <= '0;
            r_fpcr    <= '0;
            r_fpsr    <= '0;
        end else if (i_wr.en) begin
            case (i_wr.sel)
                SR_TPIDR:   r_tpidr   <= i_wr.data;
                SR_TPIDRRO: r_tpidrro <= i_wr.data;
                SR_FPCR:    r_fpcr    <= i_wr.data[31:0];
                SR_FPSR:    r_fpsr    <= i_wr.data[31:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (i_rd_sel)
            SR_TPIDR:   o_rd_data = r_tpidr;
            SR_TPIDRRO: o_rd_data = r_tpidrro;
            SR_CTR:     o_rd_data = {32'd0, VAL_CTR};
            SR_DCZID:   o_rd_data = {32'd0, VAL_DCZID};
            SR_NZCV:    o_rd_data = {32'd0, i_flags, 28'd0};
            SR_FPCR:    o_rd_data = {32'd0, r_fpcr};
            SR_FPSR:    o_rd_data = {32'd0, r_fpsr};
            SR_MIDR:    o_rd_data = {32'd0, VAL_MIDR};
            SR_ID_5:    o_rd_data = {32'd0, VAL_ID_5};
            SR_ID_6:    o_rd_data = {32'd0, VAL_ID_6};
            SR_ID_20:   o_rd_data = {32'd0, VAL_ID_20};
            default:    o_rd_data = '0;
        endcase
    end

endmodule

`default_nettype wire

>>> design/bsu_exec.sv
// Combinational execute logic: branch resolution, halts, syscalls, CLREX and MRS/MSR.
// Depends on bsu_pkg; takes the system register read data from bsu_sysregs.
`default_nettype none

module bsu_exec
    import bsu_pkg::*;
(
    input  wire t_in_item    i_item,
    input  wire logic [63:0] i_sr_rdata,
    output t_out_item        o_result,
    output t_sr_wr           o_sr_wr
);

    function automatic logic cond_holds(input logic [3:0] c, input logic [3:0] f);
        logic r;
        unique case (c[3:1])
            3'd0: r = f[2];
            3'd1: r = f[1];
            3'd2: r = f[3];
            3'd3: r = f[0];
            3'd4: r = f[1] & ~f[2];
            3'd5: r = (f[3] == f[0]);
            3'd6: r = ~f[2] & (f[3] == f[0]);
            default: r = 1'b1;
        endcase
        if (c[0] && (c != 4'hF)) begin
            r = ~r;
        end
        return r;
    endfunction

    logic [63:0] w_seq;
    logic [63:0] w_target;
    logic [63:0] w_cb_value;
    logic        w_cb_zero;
    logic        w_tb_set;

    assign w_seq      = i_item.pc + 64'd4;
    assign w_target   = i_item.pc + {{36{i_item.offset[27]}}, i_item.offset};
    assign w_cb_value = i_item.wide ? i_item.reg_value : {32'd0, i_item.reg_value[31:0]};
    assign w_cb_zero  = (w_cb_value == 64'd0);
    assign w_tb_set   = i_item.reg_value[i_item.bit_pos];

    always_comb begin
        o_result.next_pc         = w_seq;
        o_result.status          = ST_CONTINUE;
        o_result.halt_code       = '0;
        o_result.reg_write       = 1'b0;
        o_result.write_index     = '0;
        o_result.write_data      = '0;
        o_result.flags_write     = 1'b0;
        o_result.flags_out       = i_item.flags_in;
        o_result.clear_exclusive = 1'b0;
        o_sr_wr.en               = 1'b0;
        o_sr_wr.sel              = i_item.sysreg;
        o_sr_wr.data             = i_item.reg_value;

        unique case (i_item.op)
            OP_B: begin
                o_result.next_pc = w_target;
            end
            OP_BL: begin
                o_result.next_pc     = w_target;
                o_result.reg_write   = 1'b1;
                o_result.write_index = LINK_REG;
                o_result.write_data  = w_seq;
            end
            OP_BCOND: begin
                if (cond_holds(i_item.cond, i_item.flags_in)) begin
                    o_result.next_pc = w_target;
                end
            end
            OP_CBZ: begin
                if (w_cb_zero) begin
                    o_result.next_pc = w_target;
                end
            end
            OP_CBNZ: begin
                if (!w_cb_zero) begin
                    o_result.next_pc = w_target;
                end
            end
            OP_TBZ: begin
                if (!w_tb_set) begin
                    o_result.next_pc = w_target;
                end
            end
            OP_TBNZ: begin
                if (w_tb_set) begin
                    o_result.next_pc = w_target;
                end
            end
            OP_BR, OP_RET: begin
                o_result.next_pc = i_item.reg_value;
            end
            OP_BLR: begin
                o_result.next_pc     = i_item.reg_value;
                o_result.reg_write   = 1'b1;
                o_result.write_index = LINK_REG;
                o_result.write_data  = w_seq;
            end
            OP_SVC: begin
                o_result.status = ST_SYSCALL;
            end
            OP_BRK: begin
                o_result.status    = ST_HALTED;
                o_result.halt_code = BRK_HALT_CODE;
            end
            OP_HLT: begin
                o_result.status    = ST_HALTED;
                o_result.halt_code = i_item.imm16;
            end
            OP_CLREX: begin
                o_result.clear_exclusive = 1'b1;
            end
            OP_MRS: begin
                if (i_item.reg_index != ZERO_REG) begin
                    o_result.reg_write   = 1'b1;
                    o_result.write_index = i_item.reg_index;
                    o_result.write_data  = i_sr_rdata;
                end
            end
            OP_MSR: begin
                if (i_item.sysreg == SR_NZCV) begin
                    o_result.flags_write = 1'b1;
                    o_result.flags_out   = i_item.reg_value[31:28];
                end else begin
                    o_sr_wr.en = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

>>> design/aarch64_branch_sysreg_unit_top.sv
// Top level of the branch and system-register unit: input register, execute
// logic, system register file and result register. Depends on bsu_pkg,
// bsu_exec and bsu_sysregs.
//
// The unit accepts one decoded branch or system instruction per clock while
// o_in_stall is low, and returns one result transaction for each. An accepted
// transaction is held in the input register, is executed there by a single pass
// of combinational logic, and moves into the result register once that register
// is empty or its result is taken, so a result passes through the input register
// and then the result register. While a result is stalled the
// input register still takes one more transaction. MSR writes to TPIDR,
// TPIDRRO, FPCR and FPSR take effect as the instruction moves into the result
// register, so the next instruction already reads the new value. The writable
// system registers reset to zero.
`default_nettype none

module aarch64_branch_sysreg_unit_top
    import bsu_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [4:0]  i_op,
    input  wire logic [63:0] i_pc,
    input  wire logic [27:0] i_offset,
    input  wire logic [3:0]  i_cond,
    input  wire logic        i_wide,
    input  wire logic [5:0]  i_bit_pos,
    input  wire logic [63:0] i_reg_value,
    input  wire logic [4:0]  i_reg_index,
    input  wire logic [15:0] i_sysreg,
    input  wire logic [15:0] i_imm16,
    input  wire logic [3:0]  i_flags_in,

    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [63:0]      o_next_pc,
    output logic [1:0]       o_status,
    output logic [15:0]      o_halt_code,
    output logic             o_reg_write,
    output logic [4:0]       o_write_index,
    output logic [63:0]      o_write_data,
    output logic             o_flags_write,
    output logic [3:0]       o_flags_out,
    output logic             o_clear_exclusive
);

    logic      r_in_valid;
    logic      n_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    logic      n_out_valid;
    t_out_item r_out;

    logic      w_out_ready;
    logic      w_fire;
    logic      w_accept;
    t_out_item w_result;
    t_sr_wr    w_sr_wr;
    t_sr_wr    w_sr_wr_gated;
    logic [63:0] w_sr_rdata;

    assign w_out_ready = !r_out_valid || !i_out_stall;
    assign w_fire      = r_in_valid && w_out_ready;
    assign o_in_stall  = r_in_valid && !w_out_ready;
    assign w_accept    = i_in_valid && !o_in_stall;

    always_comb begin
        n_in_valid = r_in_valid;
        if (w_accept) begin
            n_in_valid = 1'b1;
        end else if (w_fire) begin
            n_in_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (w_fire) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in.op        <= i_op;
            r_in.pc        <= i_pc;
            r_in.offset    <= i_offset;
            r_in.cond      <= i_cond;
            r_in.wide      <= i_wide;
            r_in.bit_pos   <= i_bit_pos;
            r_in.reg_value <= i_reg_value;
            r_in.reg_index <= i_reg_index;
            r_in.sysreg    <= i_sysreg;
            r_in.imm16     <= i_imm16;
            r_in.flags_in  <= i_flags_in;
        end
        if (w_fire) begin
            r_out <= w_result;
        end
    end

    bsu_exec u_exec (
        .i_item     (r_in),
        .i_sr_rdata (w_sr_rdata),
        .o_result   (w_result),
        .o_sr_wr    (w_sr_wr)
    );

    always_comb begin
        w_sr_wr_gated    = w_sr_wr;
        w_sr_wr_gated.en = w_sr_wr.en && w_fire;
    end

    bsu_sysregs u_sysregs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_sel  (r_in.sysreg),
        .i_flags   (r_in.flags_in),
        .i_wr      (w_sr_wr_gated),
        .o_rd_data (w_sr_rdata)
    );

    assign o_out_valid       = r_out_valid;
    assign o_next_pc         = r_out.next_pc;
    assign o_status          = r_out.status;
    assign o_halt_code       = r_out.halt_code;
    assign o_reg_write       = r_out.reg_write;
    assign o_write_index     = r_out.write_index;
    assign o_write_data      = r_out.write_data;
    assign o_flags_write     = r_out.flags_write;
    assign o_flags_out       = r_out.flags_out;
    assign o_clear_exclusive = r_out.clear_exclusive;

`ifndef ASSERT_OFF
    a_fire_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> r_out_valid)
        else $error("executed transaction did not reach the result register");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall))
        else $error("input stalled while a stage was free");

    a_halt_code_only_on_halt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.status != ST_HALTED)) |-> (r_out.halt_code == 16'd0))
        else $error("halt code set without a halt");

    a_no_write_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.reg_write) |->
            ((r_out.write_index == 5'd0) && (r_out.write_data == 64'd0)))
        else $error("write index or data set without a register write");
`endif

endmodule

`default_nettype wire

>>> verif/bsu_checker.sv
// Checker for the branch and system-register unit: watches both channels, predicts each
// result from its own copy of TPIDR, TPIDRRO, FPCR and FPSR, and compares in order.
// Depends on bsu_pkg for the instruction and result types, op codes and register encodings.
`default_nettype none

module bsu_checker
    import bsu_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        i_in_valid,
    input  wire logic        i_in_stall,
    input  wire t_in_item    i_instr,

    input  wire logic        i_out_valid,
    input  wire logic        i_out_stall,
    input  wire logic [63:0] i_next_pc,
    input  wire logic [1:0]  i_status,
    input  wire logic [15:0] i_halt_code,
    input  wire logic        i_reg_write,
    input  wire logic [4:0]  i_write_index,
    input  wire logic [63:0] i_write_data,
    input  wire logic        i_flags_write,
    input  wire logic [3:0]  i_flags_out,
    input  wire logic        i_clear_exclusive,

    output int               o_fail_count,
    output int               o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [2:0] {
        CC_EQ, CC_CS, CC_MI, CC_VS, CC_HI, CC_GE, CC_GT, CC_AL
    } t_cond_base;

    localparam logic [3:0] COND_NV = 4'hF;

    logic [63:0] tpidr_q;
    logic [63:0] tpidrro_q;
    logic [31:0] fpcr_q;
    logic [31:0] fpsr_q;
    t_out_item   predicted_q[$];
    int          fail_count = 0;

    function automatic logic cond_passes(logic [3:0] cond, logic [3:0] nzcv);
        logic n, z, c, v, hit;
        n = nzcv[3];
        z = nzcv[2];
        c = nzcv[1];
        v = nzcv[0];
        case (t_cond_base'(cond[3:1]))
            CC_EQ: hit = z;
            CC_CS: hit = c;
            CC_MI: hit = n;
            CC_VS: hit = v;
            CC_HI: hit = c && !z;
            CC_GE: hit = (n == v);
            CC_GT: hit = !z && (n == v);
            default: hit = 1'b1;
        endcase
        // The odd code of each pair inverts, except that both AL and NV always pass.
        if (cond[0] && cond != COND_NV) begin
            hit = !hit;
        end
        return hit;
    endfunction

    function automatic t_out_item execute_instr(t_in_item it);
        t_out_item   res;
        logic [63:0] seq_pc;
        logic [63:0] target;
        logic [63:0] tested;
        logic [63:0] rd_val;
        seq_pc = it.pc + 64'd4;
        target = it.pc + {{36{it.offset[27]}}, it.offset};
        res = '0;
        res.next_pc = seq_pc;
        res.status = ST_CONTINUE;
        res.flags_out = it.flags_in;
        case (it.op)
            OP_B: begin
                res.next_pc = target;
            end
            OP_BL: begin
                res.next_pc = target;
                res.reg_write = 1'b1;
                res.write_index = LINK_REG;
                res.write_data = seq_pc;
            end
            OP_BCOND: begin
                if (cond_passes(it.cond, it.flags_in)) begin
                    res.next_pc = target;
                end
            end
            OP_CBZ, OP_CBNZ: begin
                tested = it.wide ? it.reg_value : {32'd0, it.reg_value[31:0]};
                if ((tested == '0) == (it.op == OP_CBZ)) begin
                    res.next_pc = target;
                end
            end
            OP_TBZ, OP_TBNZ: begin
                if (it.reg_value[it.bit_pos] == (it.op == OP_TBNZ)) begin
                    res.next_pc = target;
                end
            end
            OP_BR, OP_RET: begin
                res.next_pc = it.reg_value;
            end
            OP_BLR: begin
                res.next_pc = it.reg_value;
                res.reg_write = 1'b1;
                res.write_index = LINK_REG;
                res.write_data = seq_pc;
            end
            OP_SVC: begin
                res.status = ST_SYSCALL;
            end
            OP_BRK: begin
                res.status = ST_HALTED;
                res.halt_code = BRK_HALT_CODE;
            end
            OP_HLT: begin
                res.status = ST_HALTED;
                res.halt_code = it.imm16;
            end
            OP_CLREX: begin
                res.clear_exclusive = 1'b1;
            end
            OP_MRS: begin
                case (it.sysreg)
                    SR_TPIDR:   rd_val = tpidr_q;
                    SR_TPIDRRO: rd_val = tpidrro_q;
                    SR_CTR:     rd_val = {32'd0, VAL_CTR};
                    SR_DCZID:   rd_val = {32'd0, VAL_DCZID};
                    SR_NZCV:    rd_val = {32'd0, it.flags_in, 28'd0};
                    SR_FPCR:    rd_val = {32'd0, fpcr_q};
                    SR_FPSR:    rd_val = {32'd0, fpsr_q};
                    SR_MIDR:    rd_val = {32'd0, VAL_MIDR};
                    SR_ID_5:    rd_val = {32'd0, VAL_ID_5};
                    SR_ID_6:    rd_val = {32'd0, VAL_ID_6};
                    SR_ID_20:   rd_val = {32'd0, VAL_ID_20};
                    default:    rd_val = '0;
                endcase
                if (it.reg_index != ZERO_REG) begin
                    res.reg_write = 1'b1;
                    res.write_index = it.reg_index;
                    res.write_data = rd_val;
                end
            end
            OP_MSR: begin
                case (it.sysreg)
                    SR_NZCV: begin
                        res.flags_write = 1'b1;
                        res.flags_out = it.reg_value[31:28];
                    end
                    SR_TPIDR:   tpidr_q = it.reg_value;
                    SR_TPIDRRO: tpidrro_q = it.reg_value;
                    SR_FPCR:    fpcr_q = it.reg_value[31:0];
                    SR_FPSR:    fpsr_q = it.reg_value[31:0];
                    default: ;
                endcase
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            tpidr_q = '0;
            tpidrro_q = '0;
            fpcr_q = '0;
            fpsr_q = '0;
            predicted_q.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                predicted_q.push_back(execute_instr(i_instr));
            end
            if (i_out_valid && !i_out_stall) begin
                if (predicted_q.size() == 0) begin
                    $display("%0t ns: result transaction expected none, got next_pc %0h",
                             $time, i_next_pc);
                    fail_count++;
                end else begin
                    want = predicted_q.pop_front();
                    check_field("next_pc", want.next_pc, i_next_pc);
                    check_field("status", 64'(want.status), 64'(i_status));
                    check_field("halt_code", 64'(want.halt_code), 64'(i_halt_code));
                    check_field("reg_write", 64'(want.reg_write), 64'(i_reg_write));
                    check_field("write_index", 64'(want.write_index), 64'(i_write_index));
                    check_field("write_data", want.write_data, i_write_data);
                    check_field("flags_write", 64'(want.flags_write), 64'(i_flags_write));
                    check_field("flags_out", 64'(want.flags_out), 64'(i_flags_out));
                    check_field("clear_exclusive", 64'(want.clear_exclusive),
                                64'(i_clear_exclusive));
                end
            end
        end
        o_pending <= predicted_q.size();
        o_fail_count <= fail_count;
    end

endmodule

`default_nettype wire

>>> verif/tb.sv
// Testbench top for the branch and system-register unit: clock, reset, instruction
// stimulus, receiver stalls, watchdog and verdict. Depends on bsu_pkg, the unit's top
// level and bsu_checker, which predicts and compares every result transaction.
`default_nettype none

module tb;
    import bsu_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int         ITEMS_PER_PHASE = 256;
    localparam int         HOLD_CYCLES     = 64;
    localparam int         WATCHDOG_LIMIT  = 2000;
    localparam int         SEND_IDLE[4]    = '{0, 68, 0, 22};
    localparam int         RECV_STALL[4]   = '{0, 0, 68, 22};
    localparam logic [4:0] OP_UNUSED_TOP   = 5'd31;
    localparam logic [15:0] KNOWN_SYSREGS[11] = '{
        SR_TPIDR, SR_TPIDRRO, SR_CTR, SR_DCZID, SR_NZCV, SR_FPCR,
        SR_FPSR, SR_MIDR, SR_ID_5, SR_ID_6, SR_ID_20
    };

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    t_in_item    stim;
    logic        out_valid;
    logic        out_stall;
    logic [63:0] next_pc;
    logic [1:0]  status;
    logic [15:0] halt_code;
    logic        reg_write;
    logic [4:0]  write_index;
    logic [63:0] write_data;
    logic        flags_write;
    logic [3:0]  flags_out;
    logic        clear_exclusive;
    int          fail_count;
    int          pending;
    int          send_idle_pct;
    int          recv_stall_pct;
    logic        hold_trigger;

    aarch64_branch_sysreg_unit_top dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .o_in_stall        (in_stall),
        .i_op              (stim.op),
        .i_pc              (stim.pc),
        .i_offset          (stim.offset),
        .i_cond            (stim.cond),
        .i_wide            (stim.wide),
        .i_bit_pos         (stim.bit_pos),
        .i_reg_value       (stim.reg_value),
        .i_reg_index       (stim.reg_index),
        .i_sysreg          (stim.sysreg),
        .i_imm16           (stim.imm16),
        .i_flags_in        (stim.flags_in),
        .o_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .o_next_pc         (next_pc),
        .o_status          (status),
        .o_halt_code       (halt_code),
        .o_reg_write       (reg_write),
        .o_write_index     (write_index),
        .o_write_data      (write_data),
        .o_flags_write     (flags_write),
        .o_flags_out       (flags_out),
        .o_clear_exclusive (clear_exclusive)
    );

    bsu_checker u_checker (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .i_in_stall        (in_stall),
        .i_instr           (stim),
        .i_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .i_next_pc         (next_pc),
        .i_status          (status),
        .i_halt_code       (halt_code),
        .i_reg_write       (reg_write),
        .i_write_index     (write_index),
        .i_write_data      (write_data),
        .i_flags_write     (flags_write),
        .i_flags_out       (flags_out),
        .i_clear_exclusive (clear_exclusive),
        .o_fail_count      (fail_count),
        .o_pending         (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic t_in_item instr_of(logic [4:0] op);
        t_in_item    it;
        int unsigned pick;
        it.op = op;
        it.pc = {$urandom, $urandom};
        if ($urandom_range(9) == 0) begin
            it.pc = ~64'($urandom_range(15));
        end
        it.offset = 28'($urandom);
        if (it.offset[27:2] == 26'h1FFFFFF) begin
            it.offset[1:0] = 2'b00;
        end
        it.cond = 4'($urandom);
        it.wide = 1'($urandom);
        it.bit_pos = 6'($urandom);
        pick = $urandom_range(99);
        if (pick < 15) begin
            it.reg_value = '0;
        end else if (pick < 30) begin
            it.reg_value = {$urandom, 32'd0};
        end else begin
            it.reg_value = {$urandom, $urandom};
        end
        it.reg_index = 5'($urandom);
        it.sysreg = ($urandom_range(3) != 0) ? KNOWN_SYSREGS[$urandom_range(10)]
                                             : 16'($urandom);
        it.imm16 = 16'($urandom);
        it.flags_in = 4'($urandom);
        return it;
    endfunction

    function automatic t_in_item random_instr();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 4) begin
            return instr_of(5'($urandom_range(31, 17)));
        end else if (pick < 34) begin
            return instr_of($urandom_range(1) ? OP_MRS : OP_MSR);
        end
        return instr_of(5'($urandom_range(16, 0)));
    endfunction

    task automatic send_instr(input t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        stim <= it;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    initial begin : receiver
        int   hold_left;
        logic seen_trigger;
        hold_left = 0;
        seen_trigger = 1'b0;
        out_stall <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_trigger != seen_trigger) begin
                seen_trigger = hold_trigger;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                out_stall <= 1'b1;
                hold_left--;
            end else begin
                out_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("FAIL aarch64_branch_sysreg_unit_top");
        $finish;
    end

    initial begin : stimulus
        t_in_item it;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        stim <= '0;
        hold_trigger <= 1'b0;
        recv_stall_pct <= 0;
        send_idle_pct = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        it = instr_of(OP_B);     it.pc = '0; it.offset = 28'h7FFFFFC;   send_instr(it);
        it = instr_of(OP_B);     it.pc = '0; it.offset = 28'h8000000;   send_instr(it);
        it = instr_of(OP_BL);    it.pc = ~64'd3; it.offset = 28'd8;     send_instr(it);
        it = instr_of(OP_BCOND); it.cond = 4'd14; it.flags_in = 4'h0;   send_instr(it);
        it = instr_of(OP_BCOND); it.cond = 4'd15; it.flags_in = 4'h0;   send_instr(it);
        it = instr_of(OP_BCOND); it.cond = 4'd0; it.flags_in = 4'h4;    send_instr(it);
        it = instr_of(OP_BCOND); it.cond = 4'd1; it.flags_in = 4'h4;    send_instr(it);
        it = instr_of(OP_CBZ);   it.wide = 1'b0; it.reg_value = 64'hFFFF_FFFF_0000_0000;
        send_instr(it);
        it = instr_of(OP_CBZ);   it.wide = 1'b1; it.reg_value = 64'hFFFF_FFFF_0000_0000;
        send_instr(it);
        it = instr_of(OP_CBNZ);  it.wide = 1'b0; it.reg_value = 64'hFFFF_FFFF_0000_0000;
        send_instr(it);
        it = instr_of(OP_TBZ);   it.bit_pos = 6'd63; it.reg_value = 64'h8000_0000_0000_0000;
        send_instr(it);
        it = instr_of(OP_TBNZ);  it.bit_pos = 6'd0; it.reg_value = 64'd1;  send_instr(it);
        it = instr_of(OP_BR);    it.reg_value = '1;                     send_instr(it);
        it = instr_of(OP_BLR);   it.pc = ~64'd3; it.reg_value = '0;     send_instr(it);
        it = instr_of(OP_RET);                                          send_instr(it);
        it = instr_of(OP_SVC);                                          send_instr(it);
        it = instr_of(OP_BRK);                                          send_instr(it);
        it = instr_of(OP_HLT);   it.imm16 = 16'hFFFF;                   send_instr(it);
        it = instr_of(OP_CLREX);                                        send_instr(it);
        it = instr_of(OP_HINT);                                         send_instr(it);
        it = instr_of(OP_UNUSED_TOP);                                   send_instr(it);
        it = instr_of(OP_MSR);   it.sysreg = SR_TPIDR; it.reg_value = '1;  send_instr(it);
        it = instr_of(OP_MRS);   it.sysreg = SR_TPIDR; it.reg_index = 5'd0; send_instr(it);
        it = instr_of(OP_MSR);   it.sysreg = SR_FPCR; it.reg_value = '1;   send_instr(it);
        it = instr_of(OP_MRS);   it.sysreg = SR_FPCR; it.reg_index = LINK_REG; send_instr(it);
        it = instr_of(OP_MRS);   it.sysreg = SR_DCZID; it.reg_index = ZERO_REG; send_instr(it);
        it = instr_of(OP_MRS);   it.sysreg = 16'h0000; it.reg_index = 5'd1; send_instr(it);
        it = instr_of(OP_MSR);   it.sysreg = 16'hFFFF;                  send_instr(it);
        it = instr_of(OP_MSR);   it.sysreg = SR_NZCV; it.reg_value = 64'hA000_0000;
        send_instr(it);
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = SEND_IDLE[ph];
            recv_stall_pct <= RECV_STALL[ph];
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (ph == 0 && n == 40) begin
                    hold_trigger <= ~hold_trigger;
                end
                send_instr(random_instr());
            end
            wait_drained();
        end

        repeat (4) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS aarch64_branch_sysreg_unit_top");
        end else begin
            $display("FAIL aarch64_branch_sysreg_unit_top");
        end
        $finish;
    end

endmodule

`default_nettype wire
